// ===== hdl/fct_pkg.sv =====
`timescale 1ns / 1ps

package fct_pkg;

    // Default sizes of the tap and bin stores
    localparam int DEF_MAX_TAPS = 32;
    localparam int DEF_N_BINS   = 64;

    // Port widths
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // Bin accumulator width: holds the sum of up to 64 Q1.15 gains
    localparam int ACC_W = 22;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RHO       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd2;

    // Item kinds carried on tuser
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_STEP = 2'd1,
        OP_READ = 2'd2
    } op_t;

    // One queued command
    typedef struct packed {
        op_t                op;
        logic [4:0]         tap_idx;
        logic [15:0]        scale;
        logic [15:0]        delay;
        logic signed [15:0] noise_re;
        logic signed [15:0] noise_im;
    } cmd_t;

    // Configuration register values
    typedef struct packed {
        logic signed [15:0] rho;
        logic [14:0]        sigma;
        logic [5:0]         tap_count;
    } cfg_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic empty;
        cmd_t cmd;
    } queue_out_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WR,
        ST_SP_RD,
        ST_SP_MUL1,
        ST_SP_MUL2,
        ST_SP_WR,
        ST_AC_RD,
        ST_AC_BIN,
        ST_AC_WR,
        ST_EM_RD,
        ST_EM_OUT
    } back_state_t;

endpackage

// ===== hdl/fct_front.sv =====
`timescale 1ns / 1ps

module fct_front import fct_pkg::*; #(
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tap_index[4:0], tap_scale[20:5], delay_bin[36:21], noise_re[52:37], noise_im[68:53]
    input  logic [IN_DATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [1:0]           s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic accept;
    logic idx_ok;
    logic keep;

    // Take a word whenever the queue has room
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Unpack the word into a command
    always_comb begin
        q_cmd.op       = op_t'(s_tuser);
        q_cmd.tap_idx  = s_tdata[4:0];
        q_cmd.scale    = s_tdata[20:5];
        q_cmd.delay    = s_tdata[36:21];
        q_cmd.noise_re = s_tdata[52:37];
        q_cmd.noise_im = s_tdata[68:53];
    end

    // Drop unused kinds and taps beyond the store
    assign idx_ok = (int'(s_tdata[4:0]) < MAX_TAPS);

    always_comb begin
        case (s_tuser)
            OP_LOAD: keep = idx_ok;
            OP_STEP: keep = idx_ok;
            OP_READ: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign q_push = accept && keep;

endmodule

// ===== hdl/fct_queue.sv =====
`timescale 1ns / 1ps

module fct_queue import fct_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cmd_t       push_cmd,
    output logic       full,
    input  logic       pop,
    output queue_out_t q_out
);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QP_W:0]   count_reg, count_next;

    assign full        = (count_reg == (QP_W+1)'(QUEUE_DEPTH));
    assign q_out.empty = (count_reg == '0);
    assign q_out.cmd   = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/fct_back.sv =====
`timescale 1ns / 1ps

module fct_back import fct_pkg::*; #(
    parameter int MAX_TAPS = DEF_MAX_TAPS,
    parameter int N_BINS   = DEF_N_BINS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  queue_out_t            q_out,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // bin_re[20:0], bin_im[41:21], bin_index[47:42]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int BIN_W = (N_BINS > 1) ? $clog2(N_BINS) : 1;

    // Clamp a rounded gain to Q1.15
    function automatic logic signed [15:0] sat_q15(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Clamp a bin sum to 21 bits
    function automatic logic [20:0] sat_bin(input logic signed [ACC_W-1:0] v);
        logic [20:0] r;
        if (v > 22'sd1048575) begin
            r = 21'h0FFFFF;
        end else if (v < -22'sd1048576) begin
            r = 21'h100000;
        end else begin
            r = v[20:0];
        end
        return r;
    endfunction

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic [CNT_W-1:0] t_reg, t_next;
    logic [BIN_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] cnt_eff;

    // Tap stores
    logic [31:0]         gain_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0] gain_vld_reg;
    logic [15:0]         amp_mem [MAX_TAPS];
    logic [15:0]         dly_mem [MAX_TAPS];
    logic [IDX_W-1:0]    tap_addr;
    logic [31:0]         gain_rd_reg;
    logic                gain_ok_reg;
    logic [15:0]         amp_rd_reg;
    logic [15:0]         dly_rd_reg;
    logic                gain_we;
    logic                info_we;
    logic [31:0]         gain_wdata;
    logic signed [15:0]  g_re, g_im;

    // Bin store
    logic [2*ACC_W-1:0]      bin_mem [N_BINS];
    logic [N_BINS-1:0]       bin_vld_reg;
    logic [BIN_W-1:0]        bin_addr;
    logic [2*ACC_W-1:0]      bin_rd_reg;
    logic                    bin_ok_reg;
    logic                    bin_we;
    logic                    bin_clr;
    logic signed [ACC_W-1:0] old_re, old_im;
    logic signed [ACC_W-1:0] add_re, add_im;
    logic signed [ACC_W-1:0] new_re, new_im;

    // Accumulate pipeline
    logic signed [15:0] acc_re_reg, acc_im_reg;
    logic               acc_hit_reg;
    logic [BIN_W-1:0]   acc_bin_reg;

    // Load arithmetic
    logic signed [32:0] lre_reg, lim_reg;
    logic signed [32:0] ld_sum_re, ld_sum_im;
    logic signed [32:0] ld_sh_re, ld_sh_im;
    logic signed [15:0] ld_re, ld_im;

    // Step arithmetic
    logic [30:0]        w_reg;
    logic signed [31:0] pre_re_reg, pre_im_reg;
    logic signed [46:0] mre_reg, mim_reg;
    logic signed [48:0] pre_re_x, pre_im_x;
    logic signed [48:0] mre_x, mim_x;
    logic signed [48:0] sp_sum_re, sp_sum_im;
    logic signed [48:0] sp_sh_re, sp_sh_im;
    logic signed [15:0] sp_re, sp_im;

    // Output register
    logic        out_valid_reg;
    logic        out_load;
    logic [20:0] out_re_reg, out_im_reg;
    logic [5:0]  out_idx_reg;
    logic        out_last_reg;

    // Active tap count, capped at the store depth
    assign cnt_eff = (int'(cfg.tap_count) > MAX_TAPS) ? CNT_W'(MAX_TAPS)
                                                      : CNT_W'(cfg.tap_count);

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        t_next     = t_reg;
        b_next     = b_reg;
        q_pop      = 1'b0;
        gain_we    = 1'b0;
        info_we    = 1'b0;
        bin_we     = 1'b0;
        bin_clr    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_out.empty) begin
                    q_pop = 1'b1;
                    case (q_out.cmd.op)
                        OP_LOAD: state_next = ST_LD_MUL;
                        OP_STEP: state_next = ST_SP_RD;
                        OP_READ: begin
                            bin_clr    = 1'b1;
                            t_next     = '0;
                            b_next     = '0;
                            state_next = (cnt_eff == '0) ? ST_EM_RD : ST_AC_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LD_MUL: begin
                info_we    = 1'b1;
                state_next = ST_LD_WR;
            end
            ST_LD_WR: begin
                gain_we    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SP_RD:   state_next = ST_SP_MUL1;
            ST_SP_MUL1: state_next = ST_SP_MUL2;
            ST_SP_MUL2: state_next = ST_SP_WR;
            ST_SP_WR: begin
                gain_we    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_AC_RD:  state_next = ST_AC_BIN;
            ST_AC_BIN: state_next = ST_AC_WR;
            ST_AC_WR: begin
                bin_we     = acc_hit_reg;
                t_next     = t_reg + 1'b1;
                state_next = (t_next < cnt_eff) ? ST_AC_RD : ST_EM_RD;
            end
            ST_EM_RD: state_next = ST_EM_OUT;
            ST_EM_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load = 1'b1;
                    if (b_reg == BIN_W'(N_BINS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        b_next     = b_reg + 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            t_reg     <= '0;
            b_reg     <= '0;
        end else begin
            state_reg <= state_next;
            t_reg     <= t_next;
            b_reg     <= b_next;
        end
    end

    // Hold the command being worked on
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_out.cmd;
        end
    end

    // Tap store: one address, registered read
    assign tap_addr = (state_reg == ST_AC_RD) ? t_reg[IDX_W-1:0] : IDX_W'(cmd_reg.tap_idx);

    always_ff @(posedge aclk) begin
        if (gain_we) begin
            gain_mem[tap_addr] <= gain_wdata;
        end
        if (info_we) begin
            amp_mem[tap_addr] <= cmd_reg.scale;
            dly_mem[tap_addr] <= cmd_reg.delay;
        end
        gain_rd_reg <= gain_mem[tap_addr];
        gain_ok_reg <= gain_vld_reg[tap_addr];
        amp_rd_reg  <= amp_mem[tap_addr];
        dly_rd_reg  <= dly_mem[tap_addr];
    end

    // Gain valid bits: a never written tap reads as zero gain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_vld_reg <= '0;
        end else if (gain_we) begin
            gain_vld_reg[tap_addr] <= 1'b1;
        end
    end

    assign g_re = gain_ok_reg ? gain_rd_reg[15:0] : 16'sd0;
    assign g_im = gain_ok_reg ? gain_rd_reg[31:16] : 16'sd0;

    // Load: scale times noise, round half up to Q1.15
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LD_MUL) begin
            lre_reg <= $signed({1'b0, cmd_reg.scale}) * cmd_reg.noise_re;
            lim_reg <= $signed({1'b0, cmd_reg.scale}) * cmd_reg.noise_im;
        end
    end

    assign ld_sum_re = lre_reg + 33'sd4096;
    assign ld_sum_im = lim_reg + 33'sd4096;
    assign ld_sh_re  = ld_sum_re >>> 13;
    assign ld_sh_im  = ld_sum_im >>> 13;
    assign ld_re     = sat_q15(ld_sh_re[23:0]);
    assign ld_im     = sat_q15(ld_sh_im[23:0]);

    // Step: first products, then innovation products
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SP_MUL1) begin
            w_reg      <= 31'(cfg.sigma) * 31'(amp_rd_reg);
            pre_re_reg <= cfg.rho * g_re;
            pre_im_reg <= cfg.rho * g_im;
        end
        if (state_reg == ST_SP_MUL2) begin
            mre_reg <= $signed({1'b0, w_reg}) * cmd_reg.noise_re;
            mim_reg <= $signed({1'b0, w_reg}) * cmd_reg.noise_im;
        end
    end

    // Step: align, sum, round half up and clamp
    assign pre_re_x  = pre_re_reg;
    assign pre_im_x  = pre_im_reg;
    assign mre_x     = mre_reg;
    assign mim_x     = mim_reg;
    assign sp_sum_re = (pre_re_x <<< 13) + mre_x + 49'sd134217728;
    assign sp_sum_im = (pre_im_x <<< 13) + mim_x + 49'sd134217728;
    assign sp_sh_re  = sp_sum_re >>> 28;
    assign sp_sh_im  = sp_sum_im >>> 28;
    assign sp_re     = sat_q15(sp_sh_re[23:0]);
    assign sp_im     = sat_q15(sp_sh_im[23:0]);

    assign gain_wdata = (state_reg == ST_LD_WR) ? {ld_im, ld_re} : {sp_im, sp_re};

    // Accumulate: latch the tap gain and its bin
    always_ff @(posedge aclk) begin
        if (state_reg == ST_AC_BIN) begin
            acc_re_reg  <= g_re;
            acc_im_reg  <= g_im;
            acc_hit_reg <= (int'(dly_rd_reg) < N_BINS);
            acc_bin_reg <= dly_rd_reg[BIN_W-1:0];
        end
    end

    // Bin store: separate read and write addresses, registered read
    assign bin_addr = (state_reg == ST_AC_BIN) ? dly_rd_reg[BIN_W-1:0] : b_reg;

    assign old_re = bin_ok_reg ? bin_rd_reg[ACC_W-1:0] : '0;
    assign old_im = bin_ok_reg ? bin_rd_reg[2*ACC_W-1:ACC_W] : '0;
    assign add_re = acc_re_reg;
    assign add_im = acc_im_reg;
    assign new_re = old_re + add_re;
    assign new_im = old_im + add_im;

    always_ff @(posedge aclk) begin
        if (bin_we) begin
            bin_mem[acc_bin_reg] <= {new_im, new_re};
        end
        bin_rd_reg <= bin_mem[bin_addr];
        bin_ok_reg <= bin_vld_reg[bin_addr];
    end

    // Bin valid bits: drop all at the start of a read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_vld_reg <= '0;
        end else if (bin_clr) begin
            bin_vld_reg <= '0;
        end else if (bin_we) begin
            bin_vld_reg[acc_bin_reg] <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_re_reg   <= sat_bin(old_re);
            out_im_reg   <= sat_bin(old_im);
            out_idx_reg  <= 6'(b_reg);
            out_last_reg <= (b_reg == BIN_W'(N_BINS - 1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_idx_reg, out_im_reg, out_re_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/fading_channel_tap_engine.sv =====
`timescale 1ns / 1ps

// Fading channel tap engine: a tapped delay line of Rayleigh taps, each an AR1 process.
// Words on the slave side are load (action 0), step (1) or read (2); action 3 and taps
// at or beyond MAX_TAPS are dropped. A four-entry command queue sits behind the slave
// port, so words are taken while the back end works. The back end runs one command at
// a time through a single-port tap memory and a bin memory with separate read and write
// addresses. A step passes through two multiply stages and a round/clamp stage. A read
// does a read-modify-write of the bin of each tap below tap_count (capped at MAX_TAPS),
// then reads one bin per emitted word. It emits N_BINS words with tlast on the final
// bin, and the master-side output register lets the next bin be fetched while a word
// waits. The tap gains and bins come up zero after reset through valid bits, so no
// clearing pass is needed. Write rho, sigma and tap_count only while the engine is
// idle.
module fading_channel_tap_engine import fct_pkg::*; #(
    parameter int MAX_TAPS = DEF_MAX_TAPS,
    parameter int N_BINS   = DEF_N_BINS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tap_index[4:0], tap_scale[20:5], delay_bin[36:21], noise_re[52:37], noise_im[68:53]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // bin_re[20:0], bin_im[41:21], bin_index[47:42]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    cfg_t       cfg_reg;
    logic       q_push;
    cmd_t       q_cmd;
    logic       q_full;
    logic       q_pop;
    queue_out_t q_out;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rho       <= 16'sh7FFF;
            cfg_reg.sigma     <= '0;
            cfg_reg.tap_count <= 6'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RHO:       cfg_reg.rho       <= cfg_data[15:0];
                REG_SIGMA:     cfg_reg.sigma     <= cfg_data[14:0];
                REG_TAP_COUNT: cfg_reg.tap_count <= cfg_data[5:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    fct_front #(
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    fct_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_out    (q_out)
    );

    fct_back #(
        .MAX_TAPS (MAX_TAPS),
        .N_BINS   (N_BINS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_out    (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fct_pkg::*;

    localparam int N_TAPS         = DEF_MAX_TAPS;
    localparam int N_RESP_BINS    = DEF_N_BINS;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RAND_PHASES    = 8;
    localparam int WORDS_PER_PHASE = 42;

    // Action code the engine must drop
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One impulse-response bin as seen on the master side
    typedef struct {
        logic signed [20:0] re;
        logic signed [20:0] im;
        logic [5:0]         idx;
        logic               last;
    } bin_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Fading model state and its register copies
    logic signed [15:0] tap_re  [N_TAPS];
    logic signed [15:0] tap_im  [N_TAPS];
    logic [15:0]        tap_amp [N_TAPS];
    logic [15:0]        tap_dly [N_TAPS];
    logic signed [15:0] rho_q;
    logic [14:0]        sigma_q;
    logic [5:0]         count_q;

    bin_word_t expected_bins[$];
    int  errors      = 0;
    int  idle_cycles = 0;
    bit  idle_on     = 1'b1;
    int  hold_token  = 0;
    int  hold_ack    = 0;
    int  hold_cnt    = 0;
    int  rx_gap      = 0;

    fading_channel_tap_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Round half up, then floor by sh bits
    function automatic longint round_down(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] clamp_q15(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [20:0] clamp_bin(longint v);
        if (v > 1048575)
            return 21'h0FFFFF;
        if (v < -1048576)
            return 21'h100000;
        return v[20:0];
    endfunction

    function automatic void reset_fading_model();
        rho_q   = 16'sh7FFF;
        sigma_q = '0;
        count_q = 6'd1;
        for (int t = 0; t < N_TAPS; t++) begin
            tap_re[t]  = '0;
            tap_im[t]  = '0;
            tap_amp[t] = '0;
            tap_dly[t] = '0;
        end
    endfunction

    // Apply one accepted word to the model; a read queues every bin
    function automatic void update_fading_model(logic [1:0] act, logic [4:0] idx,
                                                logic [15:0] scale, logic [15:0] dly,
                                                logic signed [15:0] nre,
                                                logic signed [15:0] nim);
        longint    w, acc_re, acc_im;
        longint    sum_re [N_RESP_BINS];
        longint    sum_im [N_RESP_BINS];
        int        cnt;
        bin_word_t bw;
        if (act == OP_LOAD) begin
            tap_amp[idx] = scale;
            tap_dly[idx] = dly;
            tap_re[idx]  = clamp_q15(round_down(longint'(scale) * longint'(nre), 13));
            tap_im[idx]  = clamp_q15(round_down(longint'(scale) * longint'(nim), 13));
        end else if (act == OP_STEP) begin
            w      = longint'(sigma_q) * longint'(tap_amp[idx]);
            acc_re = longint'(rho_q) * longint'(tap_re[idx]) * 8192 + w * longint'(nre);
            acc_im = longint'(rho_q) * longint'(tap_im[idx]) * 8192 + w * longint'(nim);
            tap_re[idx] = clamp_q15(round_down(acc_re, 28));
            tap_im[idx] = clamp_q15(round_down(acc_im, 28));
        end else if (act == OP_READ) begin
            cnt = (count_q > N_TAPS) ? N_TAPS : count_q;
            for (int b = 0; b < N_RESP_BINS; b++) begin
                sum_re[b] = 0;
                sum_im[b] = 0;
            end
            for (int t = 0; t < cnt; t++) begin
                if (tap_dly[t] < N_RESP_BINS) begin
                    sum_re[tap_dly[t]] += tap_re[t];
                    sum_im[tap_dly[t]] += tap_im[t];
                end
            end
            for (int b = 0; b < N_RESP_BINS; b++) begin
                bw.re   = clamp_bin(sum_re[b]);
                bw.im   = clamp_bin(sum_im[b]);
                bw.idx  = b[5:0];
                bw.last = (b == N_RESP_BINS - 1);
                expected_bins.push_back(bw);
            end
        end
    endfunction

    // Offer one word after a random gap if idle_on is set, and hold it until taken
    task automatic send_word(logic [1:0] act, logic [4:0] idx, logic [15:0] scale,
                             logic [15:0] dly, logic signed [15:0] nre,
                             logic signed [15:0] nim);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {3'b000, nim, nre, dly, scale, idx};
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        update_fading_model(act, idx, scale, dly, nre, nim);
    endtask

    task automatic load_tap(logic [4:0] idx, logic [15:0] scale, logic [15:0] dly,
                            logic signed [15:0] nre, logic signed [15:0] nim);
        send_word(OP_LOAD, idx, scale, dly, nre, nim);
    endtask

    task automatic step_tap(logic [4:0] idx, logic signed [15:0] nre,
                            logic signed [15:0] nim);
        send_word(OP_STEP, idx, $urandom, $urandom, nre, nim);
    endtask

    task automatic read_bins();
        send_word(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Stop offering, wait for every bin, then let queued loads and steps finish
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers on back-to-back edges while the engine is idle
    task automatic set_config(logic signed [15:0] rho, logic [14:0] sigma,
                              logic [5:0] count);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_RHO;
        cfg_data  <= rho;
        @(posedge aclk);
        cfg_index <= REG_SIGMA;
        cfg_data  <= {1'b0, sigma};
        @(posedge aclk);
        cfg_index <= REG_TAP_COUNT;
        cfg_data  <= {10'b0, count};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rho_q   = rho;
        sigma_q = sigma;
        count_q = count;
    endtask

    function automatic logic signed [15:0] rand_noise();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return $urandom_range(0, 8191) - 4096;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_delay();
        case ($urandom_range(0, 9))
            8:       return 16'hFFFF;
            9:       return $urandom_range(N_RESP_BINS, 65535);
            default: return $urandom_range(0, N_RESP_BINS - 1);
        endcase
    endfunction

    // Saturation, rounding, shared and last bins, far delays, taps past tap_count
    task automatic test_basic_profile();
        set_config(16'sh7FFF, 15'h7FFF, 6'd4);
        load_tap(5'd0, 16'hFFFF, 16'd0, 16'sh7FFF, 16'sh8000);
        load_tap(5'd1, 16'h0000, 16'd0, -16'sd1, 16'sd1);
        load_tap(5'd2, 16'h0001, 16'd63, -16'sd1, 16'sh7FFF);
        load_tap(5'd3, 16'h2000, 16'd64, 16'sd4096, -16'sd4096);
        load_tap(5'd31, 16'hFFFF, 16'd5, 16'sd100, 16'sd100);
        read_bins();
        step_tap(5'd0, 16'sh7FFF, 16'sh8000);
        step_tap(5'd2, 16'sh8000, 16'sh7FFF);
        step_tap(5'd3, 16'sd0, 16'sd0);
        send_word(ACT_UNUSED, 5'd1, 16'hFFFF, 16'd1, 16'sh7FFF, 16'sh7FFF);
        load_tap(5'd3, 16'h2000, 16'hFFFF, 16'sd4096, 16'sd4096);
        read_bins();
    endtask

    // Most negative and zero rho, zero sigma, and a read with no active taps
    task automatic test_rho_extremes();
        set_config(16'sh8000, 15'h0000, 6'd4);
        step_tap(5'd0, rand_noise(), rand_noise());
        step_tap(5'd0, rand_noise(), rand_noise());
        step_tap(5'd1, rand_noise(), rand_noise());
        read_bins();
        set_config(16'sh0000, 15'h7FFF, 6'd4);
        step_tap(5'd2, 16'sh8000, 16'sh8000);
        read_bins();
        set_config(16'sh7FFF, 15'h0000, 6'd0);
        read_bins();
    endtask

    // Give every tap a defined profile before random reads use it
    task automatic test_load_all_taps();
        set_config(16'sh7FFF, 15'h4000, 6'd32);
        idle_on <= 1'b1;
        for (int t = 0; t < N_TAPS; t++)
            load_tap(t[4:0], rand_scale(), rand_delay(), rand_noise(), rand_noise());
        read_bins();
    endtask

    // Hold off the receiver while reads pile up behind it
    task automatic test_output_stall();
        set_config(16'sh6000, 15'h5000, 6'd32);
        idle_on    <= 1'b0;
        hold_token <= hold_token + 1;
        for (int k = 0; k < 6; k++) begin
            read_bins();
            step_tap($urandom, rand_noise(), rand_noise());
        end
        wait_drained();
        idle_on <= 1'b1;
    endtask

    // Random phases, each under its own register setting
    task automatic test_random_phases();
        int pick;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       set_config(16'sh7FFF, 15'h0000, 6'd32);
                1:       set_config(16'sh8000, 15'h7FFF, 6'd63);
                2:       set_config(16'sh0000, 15'h7FFF, 6'd0);
                3:       set_config($urandom, $urandom, 6'd1);
                default: set_config($urandom, $urandom, $urandom_range(1, N_TAPS));
            endcase
            idle_on <= (p % 3 != 2);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 42)
                    step_tap($urandom, rand_noise(), rand_noise());
                else if (pick < 74)
                    load_tap($urandom, rand_scale(), rand_delay(), rand_noise(),
                             rand_noise());
                else if (pick < 88)
                    read_bins();
                else if (pick < 94)
                    send_word(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
                else
                    // pause the sender until every bin has come back
                    wait_drained();
            end
        end
    endtask

    // Master side: random gaps per word, or a long hold on request
    always @(posedge aclk) begin : bin_receiver
        int gap;
        if (aresetn) begin
            if (hold_token != hold_ack) begin
                hold_ack <= hold_token;
                hold_cnt <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else if (m_tready && m_tvalid) begin
                gap = idle_on ? $urandom_range(0, 8) : 0;
                rx_gap   <= gap;
                m_tready <= (gap == 0);
            end else if (!m_tready) begin
                if (rx_gap > 1) begin
                    rx_gap <= rx_gap - 1;
                end else begin
                    rx_gap   <= 0;
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Compare each bin with the oldest one pending; watch for a hang
    always @(posedge aclk) begin : bin_checker
        bin_word_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_bins.size() == 0) begin
                    $error("bin word with nothing pending: tdata %h tlast %b",
                           m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_bins.pop_front();
                    if (m_tdata[20:0] !== want.re) begin
                        $error("bin_re: expected %0d, got %0d", want.re,
                               $signed(m_tdata[20:0]));
                        errors++;
                    end
                    if (m_tdata[41:21] !== want.im) begin
                        $error("bin_im: expected %0d, got %0d", want.im,
                               $signed(m_tdata[41:21]));
                        errors++;
                    end
                    if (m_tdata[47:42] !== want.idx) begin
                        $error("bin_index: expected %0d, got %0d", want.idx,
                               m_tdata[47:42]);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        reset_fading_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_profile();
        test_rho_extremes();
        test_load_all_taps();
        test_output_stall();
        test_random_phases();
        wait_drained();
        if (errors == 0 && expected_bins.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/fct_pkg.sv
hdl/fct_front.sv
hdl/fct_queue.sv
hdl/fct_back.sv
hdl/fading_channel_tap_engine.sv
tb/sv/tb.sv
